### hdl/psw_pkg.sv
// Shared types, constants and the CRC-32 table for the PNG stored-stream writer.
`timescale 1ns / 1ps
`default_nettype none

package psw_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // PNG signature and chunk tags, first byte in the top bits
  localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [7:0]  ZLIB_CMF = 8'h78;
  localparam logic [7:0]  ZLIB_FLG = 8'h01;

  // One classified input transaction
  typedef struct packed {
    logic       start;   // opens a new file
    logic       filter;  // filter byte goes first
    logic       last;    // closes the file
    logic [7:0] data;
  } psw_item_t;

  // Geometry worked out from the configuration registers
  typedef struct packed {
    logic        ok;
    logic [12:0] w;
    logic [12:0] h;
    logic [14:0] w3;
    logic [27:0] raw;
    logic [31:0] zlen;
  } psw_geom_t;

  typedef logic [31:0] crc_tab_t [256];

  function automatic crc_tab_t crc_tab_build();
    crc_tab_t    t;
    logic [31:0] c;
    for (int k = 0; k < 256; k++) begin
      c = 32'(k);
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      t[k] = c;
    end
    return t;
  endfunction

  localparam crc_tab_t CRC_TABLE = crc_tab_build();

endpackage

`default_nettype wire

### hdl/psw_geom.sv
// Geometry unit: clamps width and height, works out raw size, block count and IDAT length.
`timescale 1ns / 1ps
`default_nettype none

module psw_geom
  import psw_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int BLOCK_BYTES   = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  output psw_geom_t        geom
);

  localparam logic [2:0] G_MUL  = 3'd0;
  localparam logic [2:0] G_ADD  = 3'd1;
  localparam logic [2:0] G_DIV  = 3'd2;
  localparam logic [2:0] G_ZLEN = 3'd3;
  localparam logic [2:0] G_DONE = 3'd4;

  localparam logic [16:0] MAX_D  = 17'(MAX_DIMENSION);
  localparam logic [26:0] BLK_M1 = 27'(BLOCK_BYTES - 1);

  // Reciprocal of the block size: exact floor division for dividends below 2^27
  localparam int          DIV_L   = $clog2(BLOCK_BYTES);
  localparam int          DIV_S   = 27 + DIV_L;
  localparam logic [63:0] RECIP64 = ((64'd1 << DIV_S) + 64'(BLOCK_BYTES) - 64'd1) /
                                    64'(BLOCK_BYTES);
  localparam logic [27:0] RECIP   = RECIP64[27:0];

  logic [2:0]  st_r;
  logic [12:0] width_r, height_r;
  logic [12:0] wc_r, hc_r;
  logic [14:0] w3_r;
  logic [27:0] raw_r;
  logic [26:0] dvd_r;
  logic [26:0] blk_r;
  logic [31:0] zlen_r;

  logic [12:0] wc, hc;
  logic [14:0] w3;
  logic [54:0] prod, quo;

  // Clamp the registers into range
  always_comb begin
    if (width_r == 13'd0)             wc = 13'd1;
    else if ({4'b0, width_r} > MAX_D) wc = MAX_D[12:0];
    else                              wc = width_r;
    if (height_r == 13'd0)             hc = 13'd1;
    else if ({4'b0, height_r} > MAX_D) hc = MAX_D[12:0];
    else                               hc = height_r;
    w3   = {2'b0, wc} + {1'b0, wc, 1'b0};
    prod = {28'b0, dvd_r} * {27'b0, RECIP};
    quo  = prod >> DIV_S;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= G_MUL;
      width_r  <= 13'd1;
      height_r <= 13'd1;
    end else if (cfg_wr) begin
      if (cfg_index == REG_WIDTH) width_r <= cfg_data;
      else                        height_r <= cfg_data;
      st_r <= G_MUL;
    end else begin
      case (st_r)
        G_MUL: begin
          wc_r  <= wc;
          hc_r  <= hc;
          w3_r  <= w3;
          raw_r <= 28'(hc) * 28'({1'b0, w3} + 16'd1);
          st_r  <= G_ADD;
        end
        G_ADD: begin
          dvd_r <= 27'(raw_r) + BLK_M1;
          st_r  <= G_DIV;
        end
        // Block count, rounded up, by reciprocal multiplication
        G_DIV: begin
          blk_r <= quo[26:0];
          st_r  <= G_ZLEN;
        end
        G_ZLEN: begin
          zlen_r <= 32'(raw_r) + 32'd6 + {3'b0, blk_r, 2'b0} + 32'(blk_r);
          st_r   <= G_DONE;
        end
        G_DONE: st_r <= G_DONE;
        default: st_r <= G_MUL;
      endcase
    end
  end

  assign geom.ok   = (st_r == G_DONE);
  assign geom.w    = wc_r;
  assign geom.h    = hc_r;
  assign geom.w3   = w3_r;
  assign geom.raw  = raw_r;
  assign geom.zlen = zlen_r;

endmodule

`default_nettype wire

### hdl/psw_front.sv
// Front end: accepts image bytes and classifies each as file start, row start, file end.
`timescale 1ns / 1ps
`default_nettype none

module psw_front
  import psw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        abort,
  input  psw_geom_t        geom,
  input  wire logic        in_valid,
  input  wire logic [7:0]  in_pixel_byte,
  output logic             in_stall,
  input  wire logic        q_full,
  output logic             q_push,
  output psw_item_t        q_item
);

  logic        active_r;
  logic [14:0] col_r;
  logic [25:0] rl_r;

  logic        start;
  logic [25:0] rl0, rl1, rl2;
  logic [14:0] col0, col_inc;
  logic        filter;

  assign in_stall = !geom.ok || q_full;
  assign q_push   = in_valid && !in_stall;

  // Mirror of the raw byte count: one or two raw bytes per transaction
  always_comb begin
    start   = !active_r;
    rl0     = start ? geom.raw[25:0] : rl_r;
    col0    = start ? 15'd0 : col_r;
    filter  = (col0 == 15'd0);
    rl1     = (rl0 == 26'd0) ? 26'd0 : rl0 - 26'd1;
    rl2     = (filter && rl1 != 26'd0) ? rl1 - 26'd1 : rl1;
    col_inc = col0 + 15'd1;
  end

  assign q_item.start  = start;
  assign q_item.filter = filter;
  assign q_item.last   = (rl2 == 26'd0);
  assign q_item.data   = in_pixel_byte;

  always_ff @(posedge clk) begin
    if (!rst_n || abort) begin
      active_r <= 1'b0;
      col_r    <= 15'd0;
      rl_r     <= 26'd0;
    end else if (q_push) begin
      active_r <= (rl2 != 26'd0);
      col_r    <= (col_inc >= geom.w3) ? 15'd0 : col_inc;
      rl_r     <= rl2;
    end
  end

endmodule

`default_nettype wire

### hdl/psw_fifo.sv
// Two-entry queue of classified transactions between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module psw_fifo
  import psw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  psw_item_t push_item,
  input  wire logic pop,
  output psw_item_t pop_item,
  output logic      full,
  output logic      empty
);

  psw_item_t  mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/psw_back.sv
// Back end: byte sequencer for headers, stored blocks and trailers, with CRC and Adler.
`timescale 1ns / 1ps
`default_nettype none

module psw_back
  import psw_pkg::*;
#(
  parameter int BLOCK_BYTES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  psw_geom_t        geom,
  input  wire logic        q_empty,
  input  psw_item_t        q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_file_end
);

  localparam logic [1:0] S_HDR  = 2'd0;
  localparam logic [1:0] S_BLK  = 2'd1;
  localparam logic [1:0] S_RAW  = 2'd2;
  localparam logic [1:0] S_TAIL = 2'd3;

  localparam logic [5:0] HDR_LAST  = 6'd42;
  localparam logic [5:0] BLK_LAST  = 6'd4;
  localparam logic [5:0] TAIL_LAST = 6'd19;
  localparam logic [5:0] OUT_LIMIT = 6'd50;
  localparam logic [15:0] BLK      = 16'(BLOCK_BYTES);

  logic        cur_valid_r;
  psw_item_t   cur_r;
  logic [1:0]  st_r;
  logic [5:0]  idx_r, ocnt_r;
  logic [31:0] crc_r;
  logic [15:0] adl_lo_r, adl_hi_r;
  logic [25:0] raw_left_r;
  logic [15:0] block_left_r;
  logic        out_valid_r, out_run_last_r, out_file_end_r;
  logic [7:0]  out_byte_r;

  logic        adv, emit, crc_en, final_step, end_step;
  logic [7:0]  step_byte, hdr_byte;
  logic [31:0] crc_seed, crc_calc, crc_fin;
  logic [15:0] blk_n, blk_inv, bl_dec;
  logic [25:0] rl_dec;
  logic [16:0] lo_sum, hi_sum;
  logic [15:0] lo_nxt, hi_nxt;

  function automatic logic [7:0] be_byte(logic [31:0] v, logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  assign q_pop   = !cur_valid_r && !q_empty;
  assign adv     = cur_valid_r && (!out_valid_r || !out_stall);
  assign emit    = (ocnt_r < OUT_LIMIT);
  assign crc_fin = ~crc_r;
  assign blk_n   = (raw_left_r > 26'(BLK)) ? BLK : raw_left_r[15:0];
  assign blk_inv = ~blk_n;
  assign bl_dec  = (block_left_r == 16'd0) ? 16'd0 : block_left_r - 16'd1;
  assign rl_dec  = (raw_left_r == 26'd0) ? 26'd0 : raw_left_r - 26'd1;

  // Opening burst: signature, IHDR, IDAT length and tag, zlib header
  always_comb begin
    case (idx_r)
      6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7:
        hdr_byte = PNG_SIG[8 * (7 - int'(idx_r[2:0])) +: 8];
      6'd11:                       hdr_byte = 8'd13;
      6'd12, 6'd13, 6'd14, 6'd15:  hdr_byte = be_byte(TAG_IHDR, idx_r[1:0]);
      6'd16, 6'd17, 6'd18, 6'd19:  hdr_byte = be_byte({19'b0, geom.w}, idx_r[1:0]);
      6'd20, 6'd21, 6'd22, 6'd23:  hdr_byte = be_byte({19'b0, geom.h}, idx_r[1:0]);
      6'd24:                       hdr_byte = 8'd8;
      6'd25:                       hdr_byte = 8'd2;
      6'd29, 6'd30, 6'd31, 6'd32:  hdr_byte = be_byte(crc_fin, 2'(idx_r - 6'd29));
      6'd33, 6'd34, 6'd35, 6'd36:  hdr_byte = be_byte(geom.zlen, 2'(idx_r - 6'd33));
      6'd37, 6'd38, 6'd39, 6'd40:  hdr_byte = be_byte(TAG_IDAT, 2'(idx_r - 6'd37));
      6'd41:                       hdr_byte = ZLIB_CMF;
      6'd42:                       hdr_byte = ZLIB_FLG;
      default:                     hdr_byte = 8'd0;
    endcase
  end

  // Byte of the current step and whether it enters the CRC
  always_comb begin
    step_byte  = 8'd0;
    crc_en     = 1'b0;
    crc_seed   = crc_r;
    final_step = 1'b0;
    end_step   = 1'b0;
    case (st_r)
      S_HDR: begin
        step_byte = hdr_byte;
        crc_en    = (idx_r >= 6'd12 && idx_r <= 6'd28) || (idx_r >= 6'd37);
        if (idx_r == 6'd12 || idx_r == 6'd37) crc_seed = CRC_INIT;
      end
      S_BLK: begin
        crc_en = 1'b1;
        case (idx_r)
          6'd0:    step_byte = {7'b0, (26'(blk_n) == raw_left_r)};
          6'd1:    step_byte = blk_n[7:0];
          6'd2:    step_byte = blk_n[15:8];
          6'd3:    step_byte = blk_inv[7:0];
          default: step_byte = blk_inv[15:8];
        endcase
      end
      S_RAW: begin
        step_byte  = cur_r.filter ? 8'd0 : cur_r.data;
        crc_en     = 1'b1;
        final_step = !cur_r.filter && !cur_r.last;
      end
      S_TAIL: begin
        crc_en = (idx_r <= 6'd3) || (idx_r >= 6'd12 && idx_r <= 6'd15);
        if (idx_r == 6'd12) crc_seed = CRC_INIT;
        final_step = (idx_r == TAIL_LAST);
        end_step   = final_step;
        if (idx_r <= 6'd3)       step_byte = be_byte({adl_hi_r, adl_lo_r}, idx_r[1:0]);
        else if (idx_r <= 6'd7)  step_byte = be_byte(crc_fin, idx_r[1:0]);
        else if (idx_r <= 6'd11) step_byte = 8'd0;
        else if (idx_r <= 6'd15) step_byte = be_byte(TAG_IEND, idx_r[1:0]);
        else                     step_byte = be_byte(crc_fin, idx_r[1:0]);
      end
      default: step_byte = 8'd0;
    endcase
    crc_calc = CRC_TABLE[crc_seed[7:0] ^ step_byte] ^ {8'b0, crc_seed[31:8]};
  end

  // Adler-32 sums with conditional subtraction
  always_comb begin
    lo_sum = {1'b0, adl_lo_r} + {9'b0, step_byte};
    lo_nxt = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    hi_sum = {1'b0, adl_hi_r} + {1'b0, lo_nxt};
    hi_nxt = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      st_r         <= S_HDR;
      idx_r        <= 6'd0;
      ocnt_r       <= 6'd0;
      crc_r        <= CRC_INIT;
      adl_lo_r     <= 16'd1;
      adl_hi_r     <= 16'd0;
      raw_left_r   <= 26'd0;
      block_left_r <= 16'd0;
    end else begin
      // Output register: load on a step, clear once taken
      if (adv)             out_valid_r <= emit;
      else if (!out_stall) out_valid_r <= 1'b0;
      // Take the next transaction from the queue
      if (q_pop) begin
        cur_r       <= q_item;
        cur_valid_r <= 1'b1;
        idx_r       <= 6'd0;
        ocnt_r      <= 6'd0;
        if (q_item.start)               st_r <= S_HDR;
        else if (block_left_r == 16'd0) st_r <= S_BLK;
        else                            st_r <= S_RAW;
      end
      // One byte of the sequence a cycle while a transaction is held and the output is not stalled
      if (adv) begin
        if (emit) begin
          out_byte_r     <= step_byte;
          out_run_last_r <= final_step || (ocnt_r == OUT_LIMIT - 6'd1);
          out_file_end_r <= end_step;
        end
        if (ocnt_r != 6'h3F) ocnt_r <= ocnt_r + 6'd1;
        if (crc_en) crc_r <= crc_calc;
        case (st_r)
          S_HDR: begin
            if (idx_r == HDR_LAST) begin
              st_r         <= S_BLK;
              idx_r        <= 6'd0;
              raw_left_r   <= geom.raw[25:0];
              block_left_r <= 16'd0;
              adl_lo_r     <= 16'd1;
              adl_hi_r     <= 16'd0;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
          S_BLK: begin
            if (idx_r == BLK_LAST) begin
              block_left_r <= blk_n;
              st_r         <= S_RAW;
              idx_r        <= 6'd0;
            end else begin
              idx_r <= idx_r + 6'd1;
            end
          end
          S_RAW: begin
            adl_lo_r     <= lo_nxt;
            adl_hi_r     <= hi_nxt;
            block_left_r <= bl_dec;
            raw_left_r   <= rl_dec;
            if (cur_r.filter) begin
              cur_r.filter <= 1'b0;
              st_r         <= (bl_dec == 16'd0) ? S_BLK : S_RAW;
            end else if (cur_r.last) begin
              st_r  <= S_TAIL;
              idx_r <= 6'd0;
            end else begin
              cur_valid_r <= 1'b0;
            end
          end
          S_TAIL: begin
            if (idx_r == TAIL_LAST) cur_valid_r <= 1'b0;
            else                    idx_r <= idx_r + 6'd1;
          end
          default: st_r <= S_HDR;
        endcase
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_run_last_r;
  assign out_file_end = out_file_end_r;

  a_file_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_file_end_r |-> out_run_last_r)
    else $error("file end without run end");

  a_blk_index: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && st_r == S_BLK |-> idx_r <= BLK_LAST)
    else $error("block header index out of range");

  a_tail_releases: assert property (@(posedge clk) disable iff (!rst_n)
    adv && st_r == S_TAIL && idx_r == TAIL_LAST |=> !cur_valid_r)
    else $error("transaction still held after trailer");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> !q_pop)
    else $error("queue popped while a transaction is in progress");

endmodule

`default_nettype wire

### hdl/png_stored_stream_writer_core.sv
// Top level of the PNG stored-stream writer: geometry, front end, queue and back end.
//
// Usage: configure image_width (cfg_index 0) and image_height (cfg_index 1) through
// the cfg_ write channel (always ready), then send R,G,B bytes row-major on in_.
// Each in_ transaction yields one or more out_ transactions carrying the PNG file
// bytes; out_run_last marks the last byte caused by an input byte, out_file_end the
// final byte of the IEND CRC. After the last image byte the next input starts a new
// file with the same geometry; a register write aborts any file in progress.
// Throughput: the back end emits one byte a cycle while out_ is not stalled; a plain
// pixel byte is first loaded from the queue and then emitted, before the next is loaded.
// The first byte of a file adds 43 header bytes, a row start one filter byte, each
// stored block five header bytes, the last byte a 20-byte trailer.
// Path: an accepted byte is written into the queue, loaded into the sequencer, then
// registered at the output, where out_valid rises.
// After reset and after each register write the geometry unit steps through multiply,
// offset, reciprocal multiply for the block count and length, with in_stall high.
// A stalled out_ holds its byte; the two-entry queue lets the input keep flowing
// until it fills, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module png_stored_stream_writer_core
  import psw_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096,
  parameter int BLOCK_BYTES   = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_pixel_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic             out_file_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data
);

  psw_geom_t geom;
  psw_item_t push_item, pop_item;
  logic      cfg_wr, q_push, q_pop, q_full, q_empty;

  // Register writes to known indexes only
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready &&
                     (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  psw_geom #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .BLOCK_BYTES   (BLOCK_BYTES)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  psw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .abort         (cfg_wr),
    .geom          (geom),
    .in_valid      (in_valid),
    .in_pixel_byte (in_pixel_byte),
    .in_stall      (in_stall),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  psw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  psw_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .geom         (geom),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_file_end (out_file_end)
  );

endmodule

`default_nettype wire
